@@ hw/rtl/lgsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lgsf_pkg: shared types and constants for the linear gradient span fill
// Sequencer states, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package lgsf_pkg;

  localparam int unsigned ArgbW    = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned LenW     = 7;
  localparam int unsigned GradW    = 16;
  localparam int unsigned FracW    = 16;
  localparam int unsigned DvdW     = ChanW + FracW;
  localparam int unsigned StepW    = DvdW + 1;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PIX,
    ST_CHAN,
    ST_OUT
  } lgsf_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_COLOUR = 2'd0,
    CFG_END_COLOUR   = 2'd1,
    CFG_GRAD_WIDTH   = 2'd2
  } cfg_idx_e;

endpackage

@@ hw/rtl/lgsf_span_if.sv @@
// ----------------------------------------------------------------------------
// lgsf_span_if: span request channel
// Valid/ready channel carrying the signed start position and pixel count.
// ----------------------------------------------------------------------------
interface lgsf_span_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] span_start;
  logic        [6:0]            span_length;

  modport source (output valid, output span_start, output span_length, input ready);
  modport sink   (input valid, input span_start, input span_length, output ready);
endinterface

@@ hw/rtl/lgsf_pix_if.sv @@
// ----------------------------------------------------------------------------
// lgsf_pix_if: pixel result channel
// Valid/ready channel carrying one packed ARGB pixel and its end-of-span flag.
// ----------------------------------------------------------------------------
interface lgsf_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic        last_pixel;

  modport source (output valid, output pixel_argb, output last_pixel, input ready);
  modport sink   (input valid, input pixel_argb, input last_pixel, output ready);
endinterface

@@ hw/rtl/linear_gradient_span_fill.sv @@
// ----------------------------------------------------------------------------
// linear_gradient_span_fill: ARGB linear gradient span generator
// Step set-up: after a request transfer, a set-up step and the shared restoring divider
//   form the per-channel signed 9.16 steps, channels 0 to 3 in turn; each pixel then
//   passes ST_PIX and, when it is interpolated, ST_CHAN before it is shown in ST_OUT.
// Pixels: interpolated channels go through one shared multiplier, one channel per cycle;
//   a span holds the block until its last pixel transfers.
// Reset: asynchronous, active low; configuration and sequencer registers read zero,
//   sequencer idle; datapath registers are not reset.
// ----------------------------------------------------------------------------
module linear_gradient_span_fill #(
  parameter int unsigned MAX_SPAN   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lgsf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lgsf_pkg::ArgbW-1:0]   cfg_wdata_i,
  lgsf_span_if.sink                    span_i,
  lgsf_pix_if.source                   pix_o
);
  import lgsf_pkg::*;

  localparam int unsigned XW     = (COORD_BITS + 1 > GradW + 1) ? COORD_BITS + 1 : GradW + 1;
  localparam int unsigned ProdW  = GradW + 1 + StepW;
  localparam int unsigned LastBit = DvdW - 1;

  lgsf_state_e state_q, state_d;

  logic [ArgbW-1:0] c0_q, c1_q;
  logic [GradW-1:0] gw_q;
  logic [GradW-1:0] g;

  logic [1:0]            ch_q;
  logic [4:0]            bit_q;
  logic                  prime_q;
  logic [LenW-1:0]       rem_cnt_q;
  logic signed [XW-1:0]  x_q;

  logic [DvdW-1:0]       dvd_q;
  logic [GradW-1:0]      prem_q;
  logic                  neg_q;
  logic signed [StepW-1:0] step_q [NumChan];
  logic [ArgbW-1:0]      pix_q;

  logic span_xfer, pix_xfer;
  logic [LenW-1:0] len_sat;
  logic interp;

  // divider datapath
  logic [ChanW-1:0]  a_div, b_div;
  logic signed [ChanW:0] diff;
  logic [ChanW-1:0]  diff_mag;
  logic [GradW:0]    trial;
  logic              qbit;
  logic [DvdW-1:0]   dvd_next;
  logic [GradW-1:0]  prem_next;
  logic [1:0]        ch_nxt;

  // interpolation datapath
  logic [ChanW-1:0]        a_pix;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] acc;
  logic [ChanW-1:0]        chan_val;

  assign g = (gw_q == '0) ? '0 : gw_q - GradW'(1);

  assign span_xfer = span_i.valid && span_i.ready;
  assign pix_xfer  = pix_o.valid && pix_o.ready;
  assign len_sat   = (span_i.span_length > LenW'(MAX_SPAN)) ? LenW'(MAX_SPAN)
                                                            : span_i.span_length;

  assign interp = !x_q[XW-1] && (x_q < $signed({{(XW-GradW){1'b0}}, g}));

  // restoring division of |c1 - c0| << 16 by g, one quotient bit a cycle
  assign ch_nxt    = ch_q + 2'd1;
  assign a_div     = c0_q[{ch_nxt, 3'b000} +: ChanW];
  assign b_div     = c1_q[{ch_nxt, 3'b000} +: ChanW];
  assign diff      = $signed({1'b0, b_div}) - $signed({1'b0, a_div});
  assign diff_mag  = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
  assign trial     = {prem_q, dvd_q[DvdW-1]};
  assign qbit      = (trial >= {1'b0, g});
  assign prem_next = qbit ? GradW'(trial - {1'b0, g}) : trial[GradW-1:0];
  assign dvd_next  = {dvd_q[DvdW-2:0], qbit};

  // one channel per cycle through the shared multiplier
  assign a_pix    = c0_q[{ch_q, 3'b000} +: ChanW];
  assign prod     = $signed({1'b0, x_q[GradW-1:0]}) * step_q[ch_q];
  assign acc      = $signed({{(ProdW-ChanW-FracW){1'b0}}, a_pix, {FracW{1'b0}}}) + prod;
  assign chan_val = acc[ProdW-1] ? '0 :
                    (|acc[ProdW-2:FracW+ChanW]) ? {ChanW{1'b1}} : acc[FracW+ChanW-1:FracW];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
      c1_q <= '0;
      gw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_COLOUR: c0_q <= cfg_wdata_i;
        CFG_END_COLOUR:   c1_q <= cfg_wdata_i;
        CFG_GRAD_WIDTH:   gw_q <= cfg_wdata_i[GradW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (span_xfer && (span_i.span_length != '0)) state_d = ST_DIV;
      ST_DIV:  if (!prime_q && (bit_q == 5'(LastBit)) && (ch_q == 2'd3)) state_d = ST_PIX;
      ST_PIX:  state_d = interp ? ST_CHAN : ST_OUT;
      ST_CHAN: if (ch_q == 2'd3) state_d = ST_OUT;
      ST_OUT:  if (pix_o.ready) state_d = (rem_cnt_q == LenW'(1)) ? ST_IDLE : ST_PIX;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    span_i.ready     = (state_q == ST_IDLE);
    pix_o.valid      = (state_q == ST_OUT);
    pix_o.pixel_argb = pix_q;
    pix_o.last_pixel = (rem_cnt_q == LenW'(1));
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= '0;
      bit_q     <= '0;
      prime_q   <= 1'b0;
      rem_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (span_xfer) begin
        ch_q      <= 2'd3;
        bit_q     <= 5'(LastBit);
        prime_q   <= 1'b1;
        rem_cnt_q <= len_sat;
      end else if (state_q == ST_DIV) begin
        prime_q <= 1'b0;
        if (bit_q == 5'(LastBit)) begin
          bit_q <= '0;
          ch_q  <= ch_nxt;
        end else begin
          bit_q <= bit_q + 5'd1;
        end
      end else if (state_q == ST_CHAN) begin
        ch_q <= ch_nxt;
      end else if (pix_xfer) begin
        rem_cnt_q <= rem_cnt_q - LenW'(1);
      end
    end
  end

  // datapath: divider, steps, position and pixel assembly
  always_ff @(posedge clk_i) begin
    if (span_xfer) begin
      x_q <= XW'(span_i.span_start);
    end else if (pix_xfer) begin
      x_q <= x_q + XW'(1);
    end
    // the cycle after a request transfer is a dummy last bit that only loads channel 0
    if (span_xfer) begin
      dvd_q  <= '0;
      prem_q <= '0;
    end else if (state_q == ST_DIV) begin
      if (bit_q == 5'(LastBit)) begin
        if (!prime_q) begin
          step_q[ch_q] <= neg_q ? -$signed({1'b0, dvd_next}) : $signed({1'b0, dvd_next});
        end
        dvd_q  <= {diff_mag, {FracW{1'b0}}};
        prem_q <= '0;
        neg_q  <= diff[ChanW];
      end else begin
        dvd_q  <= dvd_next;
        prem_q <= prem_next;
      end
    end
    if (state_q == ST_PIX) begin
      pix_q <= x_q[XW-1] ? c0_q : c1_q;
    end else if (state_q == ST_CHAN) begin
      pix_q[{ch_q, 3'b000} +: ChanW] <= chan_val;
    end
  end

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(span_i.ready && pix_o.valid))
    else $error("request and pixel channels active together");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_xfer && (span_i.span_length != '0) |=> (state_q == ST_DIV) && (ch_q == 2'd3))
    else $error("span did not start step set-up");

  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid |-> (rem_cnt_q != '0) && (rem_cnt_q <= LenW'(MAX_SPAN)))
    else $error("pixel shown with bad remaining count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer && pix_o.last_pixel |=> span_i.ready)
    else $error("block not idle after last pixel");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (bit_q <= 5'(LastBit)))
    else $error("divider bit counter out of range");

endmodule
